// ===== design/mds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mds_pkg
// Shared types, constants and the seven-segment font of the display scanner.
// ----------------------------------------------------------------------------
package mds_pkg;

    // Default geometry of the display.
    localparam int CHAR_DIGITS_DEF = 6;
    localparam int LED_GROUPS_DEF  = 5;

    // Digits per window; the first two windows can show a decimal point.
    localparam int WINDOW_SIZE = 3;

    // Font covers the character codes from TABLE_BASE up, TABLE_SIZE entries.
    localparam logic [7:0] TABLE_BASE = 8'h2F;
    localparam int         TABLE_SIZE = 44;
    localparam logic [7:0] TABLE_LAST = 8'(TABLE_BASE + TABLE_SIZE - 1);

    // Configuration register map, indexed by the word address.
    localparam int  PADDR_W   = 3;
    localparam logic REG_W1_DP = 1'b0;
    localparam logic REG_W2_DP = 1'b1;

    // Kind of an input beat.
    typedef enum logic {
        REQ_SCAN  = 1'b0,
        REQ_WRITE = 1'b1
    } req_type_t;

    // Decimal point selection of both windows.
    typedef struct packed {
        logic [1:0] win1;
        logic [1:0] win2;
    } dp_cfg_t;

    // Decoded drive of one scan position.
    typedef struct packed {
        logic [7:0] seg;
        logic       oor;
    } seg_word_t;

    // Segment pattern, bit 0 = a through bit 6 = g, for code TABLE_BASE + idx.
    function automatic logic [6:0] seg_font(input logic [5:0] idx);
        logic [6:0] pat;
        case (idx)
            6'd0:    pat = 7'h00;
            6'd1:    pat = 7'h3F;
            6'd2:    pat = 7'h06;
            6'd3:    pat = 7'h5B;
            6'd4:    pat = 7'h4F;
            6'd5:    pat = 7'h66;
            6'd6:    pat = 7'h6D;
            6'd7:    pat = 7'h7D;
            6'd8:    pat = 7'h07;
            6'd9:    pat = 7'h7F;
            6'd10:   pat = 7'h6F;
            6'd11:   pat = 7'h3F;
            6'd12:   pat = 7'h06;
            6'd13:   pat = 7'h5B;
            6'd14:   pat = 7'h4F;
            6'd15:   pat = 7'h66;
            6'd16:   pat = 7'h6D;
            6'd17:   pat = 7'h7D;
            6'd18:   pat = 7'h77;
            6'd19:   pat = 7'h7C;
            6'd20:   pat = 7'h39;
            6'd21:   pat = 7'h5E;
            6'd22:   pat = 7'h79;
            6'd23:   pat = 7'h71;
            6'd24:   pat = 7'h3D;
            6'd25:   pat = 7'h76;
            6'd26:   pat = 7'h06;
            6'd27:   pat = 7'h1E;
            6'd28:   pat = 7'h70;
            6'd29:   pat = 7'h38;
            6'd30:   pat = 7'h55;
            6'd31:   pat = 7'h54;
            6'd32:   pat = 7'h5C;
            6'd33:   pat = 7'h73;
            6'd34:   pat = 7'h67;
            6'd35:   pat = 7'h50;
            6'd36:   pat = 7'h6D;
            6'd37:   pat = 7'h78;
            6'd38:   pat = 7'h3E;
            6'd39:   pat = 7'h1C;
            6'd40:   pat = 7'h6A;
            6'd41:   pat = 7'h04;
            6'd42:   pat = 7'h6E;
            6'd43:   pat = 7'h49;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

endpackage

// ===== design/mds_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mds_buffer
// Display buffer: characters followed by LED group bytes, one write port and
// one read port addressed by the scan position.
// ----------------------------------------------------------------------------
module mds_buffer
    import mds_pkg::*;
#(
    parameter int DEPTH = CHAR_DIGITS_DEF + LED_GROUPS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] buf_reg [DEPTH];

    // Storage; reset shows every slot as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                buf_reg[i] <= 8'h00;
            end
        end
        else if (wr_en)
        begin
            buf_reg[wr_addr] <= wr_data;
        end
    end

    // The read address is always kept below DEPTH by the scan counter.
    assign rd_data = buf_reg[rd_addr];

endmodule

// ===== design/mds_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mds_decode
// Turns the buffer byte of one scan position into segment drive and the
// out-of-range flag.
// ----------------------------------------------------------------------------
module mds_decode
    import mds_pkg::*;
#(
    parameter int CHAR_DIGITS = CHAR_DIGITS_DEF,
    parameter int POS_W = 4
)
(
    input  logic [POS_W-1:0] pos,
    input  logic [7:0]       value,
    input  dp_cfg_t          dp_cfg,
    output seg_word_t        word
);

    localparam logic [POS_W:0] CHAR_LIMIT = (POS_W + 1)'(CHAR_DIGITS);
    localparam logic [POS_W:0] W1_D1 = (POS_W + 1)'(0);
    localparam logic [POS_W:0] W1_D2 = (POS_W + 1)'(1);
    localparam logic [POS_W:0] W2_D1 = (POS_W + 1)'(WINDOW_SIZE);
    localparam logic [POS_W:0] W2_D2 = (POS_W + 1)'(WINDOW_SIZE + 1);

    logic [POS_W:0] pos_x;
    logic           is_char;
    logic           in_font;
    logic [5:0]     font_idx;
    logic           dp_on;
    logic [7:0]     diff;

    assign pos_x    = {1'b0, pos};
    assign is_char  = pos_x < CHAR_LIMIT;
    assign in_font  = (value >= TABLE_BASE) && (value <= TABLE_LAST);
    assign diff     = value - TABLE_BASE;
    assign font_idx = diff[5:0];

    // Decimal point only on the first two digits of the first two windows.
    always_comb
    begin
        dp_on = 1'b0;
        if (pos_x == W1_D1)
        begin
            dp_on = dp_cfg.win1 == 2'd1;
        end
        else if (pos_x == W1_D2)
        begin
            dp_on = dp_cfg.win1 == 2'd2;
        end
        else if (pos_x == W2_D1)
        begin
            dp_on = dp_cfg.win2 == 2'd1;
        end
        else if (pos_x == W2_D2)
        begin
            dp_on = dp_cfg.win2 == 2'd2;
        end
    end

    // Character positions use the font; LED positions drive the inverted byte.
    always_comb
    begin
        word.seg = 8'h00;
        word.oor = 1'b0;
        if (is_char)
        begin
            if (in_font)
            begin
                word.seg = {dp_on, seg_font(font_idx)};
            end
            else
            begin
                word.oor = 1'b1;
            end
        end
        else
        begin
            word.seg = ~value;
        end
    end

endmodule

// ===== design/multiplexed_display_scanner.sv =====
`timescale 1ns / 1ps
// A scan tick is loaded into the input register when accepted, and its
// result goes into the result register when that register is free.
// Throughput: one beat per clock cycle unless the result channel stalls, set
// by the single decode pass between the registers; a write beat yields no result.
// Reset clears the scan position to the first position, the display buffer
// to zero and both decimal point registers to zero.
// ----------------------------------------------------------------------------
// multiplexed_display_scanner
// Scans character digits and LED groups one position per tick, driving a
// one-hot digit enable and eight segment lines; an APB port sets the decimal
// point positions.
// ----------------------------------------------------------------------------
module multiplexed_display_scanner
    import mds_pkg::*;
#(
    parameter int CHAR_DIGITS = CHAR_DIGITS_DEF,
    parameter int LED_GROUPS  = LED_GROUPS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Input channel.
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [3:0]                        write_position,
    input  logic [7:0]                        write_value,
    // Result channel.
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [CHAR_DIGITS+LED_GROUPS-1:0] digit_enable,
    output logic [7:0]                        segment_lines,
    output logic                              char_out_of_range,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [PADDR_W-1:0]                paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int TOTAL = CHAR_DIGITS + LED_GROUPS;
    localparam int POS_W = $clog2(TOTAL);
    localparam logic [POS_W:0]   TOTAL_X  = (POS_W + 1)'(TOTAL);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(TOTAL - 1);

    // Configuration registers.
    dp_cfg_t dp_cfg_reg;
    logic    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dp_cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_W1_DP: dp_cfg_reg.win1 <= pwdata[1:0];
                REG_W2_DP: dp_cfg_reg.win2 <= pwdata[1:0];
                default:   dp_cfg_reg <= dp_cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_W1_DP: prdata = {30'd0, dp_cfg_reg.win1};
            REG_W2_DP: prdata = {30'd0, dp_cfg_reg.win2};
            default:   prdata = 32'd0;
        endcase
    end

    // Input register.
    logic       s1_valid_reg;
    req_type_t  s1_type_reg;
    logic [3:0] s1_pos_reg;
    logic [7:0] s1_value_reg;

    logic out_valid_reg;
    logic out_free;
    logic s1_is_scan;
    logic advance;

    assign out_free   = !out_valid_reg || out_ready;
    assign s1_is_scan = s1_type_reg == REQ_SCAN;
    assign advance    = s1_valid_reg && (!s1_is_scan || out_free);
    assign in_ready   = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_type_reg  <= req_type_t'(req_type);
            s1_pos_reg   <= write_position;
            s1_value_reg <= write_value;
        end
    end

    // Buffer writes take effect when the write beat leaves the input register.
    logic             wr_en;
    logic [POS_W-1:0] scan_pos_reg;
    logic [POS_W-1:0] scan_pos_next;
    logic [7:0]       rd_value;

    assign wr_en = advance && !s1_is_scan && ({1'b0, s1_pos_reg} < 5'(TOTAL));

    mds_buffer #(
        .DEPTH  (TOTAL),
        .ADDR_W (POS_W)
    ) u_buffer (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (s1_pos_reg[POS_W-1:0]),
        .wr_data (s1_value_reg),
        .rd_addr (scan_pos_reg),
        .rd_data (rd_value)
    );

    // Scan counter wraps after the last position.
    assign scan_pos_next = (scan_pos_reg == LAST_POS) ? '0 : scan_pos_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_pos_reg <= '0;
        end
        else if (advance && s1_is_scan)
        begin
            scan_pos_reg <= scan_pos_next;
        end
    end

    // Segment decode of the current position.
    seg_word_t word;

    mds_decode #(
        .CHAR_DIGITS (CHAR_DIGITS),
        .POS_W       (POS_W)
    ) u_decode (
        .pos    (scan_pos_reg),
        .value  (rd_value),
        .dp_cfg (dp_cfg_reg),
        .word   (word)
    );

    // Result register.
    logic [TOTAL-1:0] digit_enable_reg;
    logic [7:0]       segment_lines_reg;
    logic             char_oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && s1_is_scan;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_is_scan)
        begin
            digit_enable_reg  <= TOTAL'(1) << scan_pos_reg;
            segment_lines_reg <= word.seg;
            char_oor_reg      <= word.oor;
        end
    end

    assign out_valid         = out_valid_reg;
    assign digit_enable      = digit_enable_reg;
    assign segment_lines     = segment_lines_reg;
    assign char_out_of_range = char_oor_reg;

    // Checks on the scan datapath.
    a_onehot_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(digit_enable))
        else $error("digit enable is not one-hot");

    a_blank_on_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && char_out_of_range) |-> (segment_lines == 8'h00))
        else $error("flagged character drives segments");

    a_flag_char_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && char_out_of_range) |-> (digit_enable[CHAR_DIGITS-1:0] != '0))
        else $error("range flag raised at an LED position");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, scan_pos_reg} < TOTAL_X)
        else $error("scan position beyond last position");

endmodule

// ===== test/multiplexed_display_scanner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiplexed_display_scanner_tb
// Self-checking bench for the display scanner. A driver feeds scan ticks and
// buffer writes, and a monitor checks each result beat against a model of the
// scan position, the display buffer and the decimal point settings. The run
// steps through several decimal point settings written over APB while the
// block is idle. Both channels idle at random, and the receiver once holds
// off long enough to back up the input.
// ----------------------------------------------------------------------------
module multiplexed_display_scanner_tb;
    import mds_pkg::*;

    localparam int TOTAL            = CHAR_DIGITS_DEF + LED_GROUPS_DEF;
    localparam int SETTLE_CYCLES    = 4;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD        = 60;
    localparam int NUM_PHASES       = 6;
    localparam int BEATS_PER_PHASE  = 100;

    // Decimal point settings of each random phase, extremes included.
    localparam logic [1:0] WIN1_SETTINGS [NUM_PHASES] = '{2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd3};
    localparam logic [1:0] WIN2_SETTINGS [NUM_PHASES] = '{2'd1, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3};

    // Segment patterns, bit 0 = a through bit 6 = g, from code TABLE_BASE up.
    localparam logic [6:0] FONT [TABLE_SIZE] = '{
        7'h00,
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F,
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D,
        7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h76, 7'h06, 7'h1E,
        7'h70, 7'h38, 7'h55, 7'h54, 7'h5C, 7'h73, 7'h67, 7'h50, 7'h6D, 7'h78,
        7'h3E, 7'h1C, 7'h6A, 7'h04, 7'h6E, 7'h49
    };

    typedef struct packed {
        req_type_t  kind;
        logic [3:0] slot;
        logic [7:0] value;
    } display_beat_t;

    typedef struct packed {
        logic [TOTAL-1:0] digits;
        logic [7:0]       segs;
        logic             oor;
    } scan_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 req_type = 1'b0;
    logic [3:0]           write_position = 4'd0;
    logic [7:0]           write_value = 8'd0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [TOTAL-1:0]     digit_enable;
    logic [7:0]           segment_lines;
    logic                 char_out_of_range;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = 32'd0;
    logic [31:0]          prdata;
    logic                 pready;

    // Model state of the display.
    logic [3:0]           scan_pos = 4'd0;
    logic [7:0]           disp_buf [TOTAL] = '{default: 8'h00};
    logic [1:0]           dp_win1 = 2'd0;
    logic [1:0]           dp_win2 = 2'd0;

    display_beat_t        pending_beats [$];
    scan_result_t         expected_scans [$];
    int                   error_count = 0;
    bit                   idle_on = 1'b1;
    int                   hold_requests = 0;
    int                   hold_served = 0;
    int                   hold_left = 0;
    int                   send_gap = 0;
    int                   recv_gap = 0;
    int                   quiet_cycles = 0;

    multiplexed_display_scanner dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .req_type          (req_type),
        .write_position    (write_position),
        .write_value       (write_value),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .digit_enable      (digit_enable),
        .segment_lines     (segment_lines),
        .char_out_of_range (char_out_of_range),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // Clock and reset.
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Only digits 1 and 2 of the first two windows carry a decimal point.
    function automatic logic dp_shown(input int pos);
        int win;
        int digit;
        win = pos / WINDOW_SIZE;
        digit = pos % WINDOW_SIZE + 1;
        if (digit > 2)
            return 1'b0;
        if (win == 0)
            return int'(dp_win1) == digit;
        if (win == 1)
            return int'(dp_win2) == digit;
        return 1'b0;
    endfunction

    // Drive of the current scan position; advances the scan.
    function automatic scan_result_t predict_scan();
        scan_result_t r;
        int pos;
        logic [7:0] code;
        pos = (int'(scan_pos) >= TOTAL) ? 0 : int'(scan_pos);
        code = disp_buf[pos];
        r.digits = TOTAL'(1) << pos;
        r.segs = 8'h00;
        r.oor = 1'b0;
        if (pos < CHAR_DIGITS_DEF)
        begin
            if (code >= TABLE_BASE && code <= TABLE_LAST)
                r.segs = {dp_shown(pos), FONT[int'(code - TABLE_BASE)]};
            else
                r.oor = 1'b1;
        end
        else
        begin
            r.segs = ~code;
        end
        scan_pos = (pos + 1 >= TOTAL) ? 4'd0 : 4'(pos + 1);
        return r;
    endfunction

    // Character codes lean toward the font range and its borders.
    function automatic logic [7:0] random_code();
        logic [7:0] v;
        case ($urandom_range(0, 3))
            0, 1:    v = 8'($urandom_range(int'(TABLE_BASE), int'(TABLE_LAST)));
            2:       v = $urandom_range(0, 1) ? 8'(TABLE_BASE - 8'($urandom_range(0, 1)))
                                              : 8'(TABLE_LAST + 8'($urandom_range(0, 1)));
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    function automatic display_beat_t random_beat();
        display_beat_t b;
        b.kind = ($urandom_range(0, 9) < 6) ? REQ_SCAN : REQ_WRITE;
        b.slot = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(TOTAL, 15))
                                             : 4'($urandom_range(0, TOTAL - 1));
        if (b.kind == REQ_WRITE && b.slot < CHAR_DIGITS_DEF)
            b.value = random_code();
        else
            b.value = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic push_beat(input req_type_t kind, input logic [3:0] slot,
                             input logic [7:0] value);
        pending_beats.push_back('{kind: kind, slot: slot, value: value});
    endtask

    // Wait until every beat is sent and every result has come back, then let
    // a trailing write settle inside the block.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_scans.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic write_dp_reg(input logic idx, input logic [1:0] pos);
        logic [31:0] data;
        data = $urandom;
        data[1:0] = pos;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * int'(idx));
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_W1_DP)
            dp_win1 = data[1:0];
        else
            dp_win2 = data[1:0];
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Input driver: one beat per handshake, with random idle bursts.
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || in_ready))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                send_gap <= $urandom_range(0, 2);
            end
            else if (pending_beats.size() != 0)
            begin
                display_beat_t b;
                b = pending_beats.pop_front();
                in_valid <= 1'b1;
                req_type <= b.kind;
                write_position <= b.slot;
                write_value <= b.value;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: short random stalls plus a single long hold.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_served != hold_requests)
            begin
                hold_served <= hold_served + 1;
                hold_left <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                recv_gap <= $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Monitor: check the result beat first, then predict from the input beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_scans.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %h %h %b",
                             $time, digit_enable, segment_lines, char_out_of_range);
                    error_count++;
                end
                else
                begin
                    scan_result_t want;
                    want = expected_scans.pop_front();
                    check_field("digit_enable", 32'(want.digits), 32'(digit_enable));
                    check_field("segment_lines", 32'(want.segs), 32'(segment_lines));
                    check_field("char_out_of_range", 32'(want.oor), 32'(char_out_of_range));
                end
            end
            if (in_valid && in_ready)
            begin
                if (req_type == REQ_WRITE)
                begin
                    if (int'(write_position) < TOTAL)
                        disp_buf[write_position] = write_value;
                end
                else
                begin
                    expected_scans.push_back(predict_scan());
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat or register write.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (psel && penable && pwrite && pready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, expected_scans.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        @(posedge rst_n);
        write_dp_reg(REG_W1_DP, 2'd1);
        write_dp_reg(REG_W2_DP, 2'd2);

        // Font borders, out-of-range codes, LED extremes and ignored slots.
        push_beat(REQ_WRITE, 4'd0, TABLE_BASE);
        push_beat(REQ_WRITE, 4'd1, TABLE_LAST);
        push_beat(REQ_WRITE, 4'd2, TABLE_BASE - 8'd1);
        push_beat(REQ_WRITE, 4'd3, TABLE_LAST + 8'd1);
        push_beat(REQ_WRITE, 4'd4, 8'h30);
        push_beat(REQ_WRITE, 4'd5, 8'hFF);
        push_beat(REQ_WRITE, 4'd6, 8'h00);
        push_beat(REQ_WRITE, 4'd7, 8'hA5);
        push_beat(REQ_WRITE, 4'd10, 8'hFF);
        push_beat(REQ_WRITE, 4'd11, 8'h41);
        push_beat(REQ_WRITE, 4'd15, 8'h99);
        // One full scan and the wrap back to the first position.
        repeat (TOTAL + 1) push_beat(REQ_SCAN, 4'($urandom_range(0, 15)),
                                     8'($urandom_range(0, 255)));

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drained();
            write_dp_reg(REG_W1_DP, WIN1_SETTINGS[phase]);
            write_dp_reg(REG_W2_DP, WIN2_SETTINGS[phase]);
            if (phase == 1)
                hold_requests++;
            if (phase == NUM_PHASES - 1)
                idle_on = 1'b0;
            repeat (BEATS_PER_PHASE) pending_beats.push_back(random_beat());
        end
        wait_drained();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== multiplexed_display_scanner.f =====
design/mds_pkg.sv
design/mds_buffer.sv
design/mds_decode.sv
design/multiplexed_display_scanner.sv
test/multiplexed_display_scanner_tb.sv
